FILE: hw/rtl/wia_pkg.sv
// Shared types and constants of the wide integer ALU.
`default_nettype none

package wia_pkg;

  localparam int PortLimbW = 64;
  localparam int MaxLimbs  = 4;
  localparam int ActionW   = 4;
  localparam int AmountW   = 9;
  // low bits of the shift count applied in the second stage
  localparam int FineW     = 4;

  typedef enum logic [ActionW-1:0] {
    ACT_ADD       = 4'd0,
    ACT_SUB       = 4'd1,
    ACT_AND       = 4'd2,
    ACT_OR        = 4'd3,
    ACT_XOR       = 4'd4,
    ACT_NOT       = 4'd5,
    ACT_SHL       = 4'd6,
    ACT_SHR       = 4'd7,
    ACT_NEG       = 4'd8,
    ACT_ABS       = 4'd9,
    ACT_UCMP      = 4'd10,
    ACT_SCMP      = 4'd11,
    ACT_CLEARSIGN = 4'd12,
    ACT_SEXT      = 4'd13
  } action_e;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_GT = 2'd1,
    CMP_LT = 2'd2
  } cmp_e;

  typedef struct packed {
    logic             sel_sum;
    logic             cin;
    logic             shift_op;
    logic             shift_left;
    logic [FineW-1:0] fine;
    logic             is_cmp;
    logic             is_scmp;
    logic             sign_diff;
    logic             a_zero;
    logic             a_neg;
  } front_ctrl_t;

  typedef struct packed {
    logic sel_sum;
    logic cin;
    cmp_e cmp;
    logic a_zero;
    logic a_neg;
  } mid_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wia_front.sv
// First stage: decode, adder operand set-up, coarse shift, per-limb compare.
`default_nettype none

module wia_front import wia_pkg::*; #(
  parameter int  LIMB_COUNT = 4,
  parameter int  LIMB_WIDTH = 64,
  localparam int TotalW     = LIMB_COUNT * LIMB_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [TotalW-1:0]  a_i,
  input  logic [TotalW-1:0]  b_i,
  input  logic [AmountW-1:0] amount_i,
  output logic               valid_o,
  input  logic               ready_i,
  output front_ctrl_t        ctrl_o,
  output logic [TotalW-1:0]  x_o,
  output logic [TotalW-1:0]  y_o,
  output logic [TotalW-1:0]  other_o,
  output logic [LIMB_COUNT-1:0] gt_o,
  output logic [LIMB_COUNT-1:0] lt_o
);

  action_e                 act;
  front_ctrl_t             ctrl_d, ctrl_q;
  logic [TotalW-1:0]       x_d, x_q, y_d, y_q, other_d, other_q, direct;
  logic [TotalW-1:0]       coarse;
  logic [AmountW-1:0]      coarse_amt;
  logic [LIMB_COUNT-1:0]   gt_d, gt_q, lt_d, lt_q;
  logic                    valid_q;

  assign act        = action_e'(action_i);
  assign coarse_amt = {amount_i[AmountW-1:FineW], FineW'(0)};

  for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_cmp
    assign gt_d[i] = a_i[i*LIMB_WIDTH +: LIMB_WIDTH] > b_i[i*LIMB_WIDTH +: LIMB_WIDTH];
    assign lt_d[i] = a_i[i*LIMB_WIDTH +: LIMB_WIDTH] < b_i[i*LIMB_WIDTH +: LIMB_WIDTH];
  end

  always_comb begin
    ctrl_d           = '0;
    x_d              = a_i;
    y_d              = '0;
    direct           = '0;
    ctrl_d.a_zero    = ~|a_i;
    ctrl_d.a_neg     = a_i[TotalW-1];
    ctrl_d.sign_diff = a_i[TotalW-1] ^ b_i[TotalW-1];
    ctrl_d.fine      = amount_i[FineW-1:0];
    unique case (act)
      ACT_ADD: begin
        ctrl_d.sel_sum = 1'b1;
        y_d            = b_i;
      end
      ACT_SUB: begin
        ctrl_d.sel_sum = 1'b1;
        ctrl_d.cin     = 1'b1;
        y_d            = ~b_i;
      end
      ACT_AND: direct = a_i & b_i;
      ACT_OR:  direct = a_i | b_i;
      ACT_XOR: direct = a_i ^ b_i;
      ACT_NOT: direct = ~a_i;
      ACT_SHL: begin
        ctrl_d.shift_op   = 1'b1;
        ctrl_d.shift_left = 1'b1;
      end
      ACT_SHR: ctrl_d.shift_op = 1'b1;
      ACT_NEG: begin
        ctrl_d.sel_sum = 1'b1;
        ctrl_d.cin     = 1'b1;
        x_d            = ~a_i;
      end
      ACT_ABS: begin
        // negate only when the sign bit is set, otherwise pass a + 0
        ctrl_d.sel_sum = 1'b1;
        if (a_i[TotalW-1]) begin
          ctrl_d.cin = 1'b1;
          x_d        = ~a_i;
        end
      end
      ACT_UCMP: ctrl_d.is_cmp = 1'b1;
      ACT_SCMP: begin
        ctrl_d.is_cmp  = 1'b1;
        ctrl_d.is_scmp = 1'b1;
      end
      ACT_CLEARSIGN: direct = {1'b0, a_i[TotalW-2:0]};
      ACT_SEXT: direct = {{(TotalW-LIMB_WIDTH){a_i[LIMB_WIDTH-1]}}, a_i[LIMB_WIDTH-1:0]};
      default: ;
    endcase
    // counts of the full width or more drop every bit
    coarse  = ctrl_d.shift_left ? (a_i << coarse_amt) : (a_i >> coarse_amt);
    other_d = ctrl_d.shift_op ? coarse : direct;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q  <= ctrl_d;
      x_q     <= x_d;
      y_q     <= y_d;
      other_q <= other_d;
      gt_q    <= gt_d;
      lt_q    <= lt_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign other_o = other_q;
  assign gt_o    = gt_q;
  assign lt_o    = lt_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wia_mid.sv
// Second stage: per-limb carry-select sums, fine shift, compare resolution.
`default_nettype none

module wia_mid import wia_pkg::*; #(
  parameter int  LIMB_COUNT = 4,
  parameter int  LIMB_WIDTH = 64,
  localparam int TotalW     = LIMB_COUNT * LIMB_WIDTH,
  localparam int SumW       = LIMB_COUNT * (LIMB_WIDTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  front_ctrl_t           ctrl_i,
  input  logic [TotalW-1:0]     x_i,
  input  logic [TotalW-1:0]     y_i,
  input  logic [TotalW-1:0]     other_i,
  input  logic [LIMB_COUNT-1:0] gt_i,
  input  logic [LIMB_COUNT-1:0] lt_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output mid_ctrl_t             ctrl_o,
  output logic [SumW-1:0]       s0_o,
  output logic [SumW-1:0]       s1_o,
  output logic [TotalW-1:0]     other_o
);

  localparam int LimbSumW = LIMB_WIDTH + 1;

  mid_ctrl_t          ctrl_d, ctrl_q;
  logic [SumW-1:0]    s0_d, s0_q, s1_d, s1_q;
  logic [TotalW-1:0]  other_d, other_q;
  cmp_e               ucmp;
  logic               valid_q;

  // each limb summed for both carry-in values
  for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_sum
    assign s0_d[i*LimbSumW +: LimbSumW] = {1'b0, x_i[i*LIMB_WIDTH +: LIMB_WIDTH]}
                                        + {1'b0, y_i[i*LIMB_WIDTH +: LIMB_WIDTH]};
    assign s1_d[i*LimbSumW +: LimbSumW] = {1'b0, x_i[i*LIMB_WIDTH +: LIMB_WIDTH]}
                                        + {1'b0, y_i[i*LIMB_WIDTH +: LIMB_WIDTH]}
                                        + LimbSumW'(1);
  end

  always_comb begin
    // higher limbs override lower ones
    ucmp = CMP_EQ;
    for (int i = 0; i < LIMB_COUNT; i++) begin
      if (gt_i[i]) begin
        ucmp = CMP_GT;
      end else if (lt_i[i]) begin
        ucmp = CMP_LT;
      end
    end
    ctrl_d.sel_sum = ctrl_i.sel_sum;
    ctrl_d.cin     = ctrl_i.cin;
    ctrl_d.a_zero  = ctrl_i.a_zero;
    ctrl_d.a_neg   = ctrl_i.a_neg;
    priority if (!ctrl_i.is_cmp) begin
      ctrl_d.cmp = CMP_EQ;
    end else if (ctrl_i.is_scmp && ctrl_i.sign_diff) begin
      ctrl_d.cmp = ctrl_i.a_neg ? CMP_LT : CMP_GT;
    end else begin
      ctrl_d.cmp = ucmp;
    end
    if (ctrl_i.shift_op) begin
      other_d = ctrl_i.shift_left ? (other_i << ctrl_i.fine) : (other_i >> ctrl_i.fine);
    end else begin
      other_d = other_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q  <= ctrl_d;
      s0_q    <= s0_d;
      s1_q    <= s1_d;
      other_q <= other_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign s0_o    = s0_q;
  assign s1_o    = s1_q;
  assign other_o = other_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wia_back.sv
// Third stage: carry selection across limbs and the output register.
`default_nettype none

module wia_back import wia_pkg::*; #(
  parameter int  LIMB_COUNT = 4,
  parameter int  LIMB_WIDTH = 64,
  localparam int TotalW     = LIMB_COUNT * LIMB_WIDTH,
  localparam int SumW       = LIMB_COUNT * (LIMB_WIDTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  mid_ctrl_t         ctrl_i,
  input  logic [SumW-1:0]   s0_i,
  input  logic [SumW-1:0]   s1_i,
  input  logic [TotalW-1:0] other_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [TotalW-1:0] result_o,
  output logic [1:0]        cmp_o,
  output logic              a_zero_o,
  output logic              a_neg_o
);

  localparam int LimbSumW = LIMB_WIDTH + 1;

  logic [TotalW-1:0]   sum, result_d, result_q;
  logic [LimbSumW-1:0] pick;
  logic                carry;
  cmp_e                cmp_q;
  logic                a_zero_q, a_neg_q, valid_q;

  always_comb begin
    carry = ctrl_i.cin;
    pick  = '0;
    sum   = '0;
    for (int i = 0; i < LIMB_COUNT; i++) begin
      pick = carry ? s1_i[i*LimbSumW +: LimbSumW] : s0_i[i*LimbSumW +: LimbSumW];
      sum[i*LIMB_WIDTH +: LIMB_WIDTH] = pick[LIMB_WIDTH-1:0];
      carry = pick[LIMB_WIDTH];
    end
    result_d = ctrl_i.sel_sum ? sum : other_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_d;
      cmp_q    <= ctrl_i.cmp;
      a_zero_q <= ctrl_i.a_zero;
      a_neg_q  <= ctrl_i.a_neg;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign cmp_o    = cmp_q;
  assign a_zero_o = a_zero_q;
  assign a_neg_o  = a_neg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wide_integer_alu_core.sv
// Top level of the wide integer ALU: three-stage pipeline and port packing.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    action, a_limb0..3, b_limb0..3, shift_amount
//   out      out  out_valid_o / out_ready_i  r_limb0..3, compare_code, a_is_zero, a_is_negative
//
// One item per cycle while the output is not stalled; a result passes the front, mid
// and back stage registers before it is presented at the output.
// The three stages are decode with coarse shift, per-limb adds with fine shift,
// and the carry select across limbs into the output register.
// Reset clears only the valid bits of the three stages.
// A stalled output holds each stage whose successor is full; ready ripples back.
`default_nettype none

module wide_integer_alu_core import wia_pkg::*; #(
  parameter int LIMB_COUNT = 4,
  parameter int LIMB_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ActionW-1:0]   action_i,
  input  logic [PortLimbW-1:0] a_limb0_i,
  input  logic [PortLimbW-1:0] a_limb1_i,
  input  logic [PortLimbW-1:0] a_limb2_i,
  input  logic [PortLimbW-1:0] a_limb3_i,
  input  logic [PortLimbW-1:0] b_limb0_i,
  input  logic [PortLimbW-1:0] b_limb1_i,
  input  logic [PortLimbW-1:0] b_limb2_i,
  input  logic [PortLimbW-1:0] b_limb3_i,
  input  logic [AmountW-1:0]   shift_amount_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PortLimbW-1:0] r_limb0_o,
  output logic [PortLimbW-1:0] r_limb1_o,
  output logic [PortLimbW-1:0] r_limb2_o,
  output logic [PortLimbW-1:0] r_limb3_o,
  output logic [1:0]           compare_code_o,
  output logic                 a_is_zero_o,
  output logic                 a_is_negative_o
);

  localparam int TotalW = LIMB_COUNT * LIMB_WIDTH;
  localparam int SumW   = LIMB_COUNT * (LIMB_WIDTH + 1);

  logic [PortLimbW-1:0]  a_arr [MaxLimbs];
  logic [PortLimbW-1:0]  b_arr [MaxLimbs];
  logic [PortLimbW-1:0]  r_arr [MaxLimbs];
  logic [TotalW-1:0]     a_vec, b_vec, result;

  front_ctrl_t           f_ctrl;
  mid_ctrl_t             m_ctrl;
  logic                  f_valid, f_ready, m_valid, m_ready;
  logic [TotalW-1:0]     f_x, f_y, f_other, m_other;
  logic [LIMB_COUNT-1:0] f_gt, f_lt;
  logic [SumW-1:0]       m_s0, m_s1;

  assign a_arr[0] = a_limb0_i;
  assign a_arr[1] = a_limb1_i;
  assign a_arr[2] = a_limb2_i;
  assign a_arr[3] = a_limb3_i;
  assign b_arr[0] = b_limb0_i;
  assign b_arr[1] = b_limb1_i;
  assign b_arr[2] = b_limb2_i;
  assign b_arr[3] = b_limb3_i;

  // drop limbs and bits beyond the configured width
  for (genvar i = 0; i < MaxLimbs; i++) begin : g_limb
    if (i < LIMB_COUNT) begin : g_used
      assign a_vec[i*LIMB_WIDTH +: LIMB_WIDTH] = a_arr[i][LIMB_WIDTH-1:0];
      assign b_vec[i*LIMB_WIDTH +: LIMB_WIDTH] = b_arr[i][LIMB_WIDTH-1:0];
      assign r_arr[i] = PortLimbW'(result[i*LIMB_WIDTH +: LIMB_WIDTH]);
    end else begin : g_unused
      assign r_arr[i] = '0;
    end
  end

  assign r_limb0_o = r_arr[0];
  assign r_limb1_o = r_arr[1];
  assign r_limb2_o = r_arr[2];
  assign r_limb3_o = r_arr[3];

  wia_front #(
    .LIMB_COUNT(LIMB_COUNT),
    .LIMB_WIDTH(LIMB_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .action_i (action_i),
    .a_i      (a_vec),
    .b_i      (b_vec),
    .amount_i (shift_amount_i),
    .valid_o  (f_valid),
    .ready_i  (f_ready),
    .ctrl_o   (f_ctrl),
    .x_o      (f_x),
    .y_o      (f_y),
    .other_o  (f_other),
    .gt_o     (f_gt),
    .lt_o     (f_lt)
  );

  wia_mid #(
    .LIMB_COUNT(LIMB_COUNT),
    .LIMB_WIDTH(LIMB_WIDTH)
  ) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .ctrl_i  (f_ctrl),
    .x_i     (f_x),
    .y_i     (f_y),
    .other_i (f_other),
    .gt_i    (f_gt),
    .lt_i    (f_lt),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .ctrl_o  (m_ctrl),
    .s0_o    (m_s0),
    .s1_o    (m_s1),
    .other_o (m_other)
  );

  wia_back #(
    .LIMB_COUNT(LIMB_COUNT),
    .LIMB_WIDTH(LIMB_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m_valid),
    .ready_o  (m_ready),
    .ctrl_i   (m_ctrl),
    .s0_i     (m_s0),
    .s1_i     (m_s1),
    .other_i  (m_other),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (result),
    .cmp_o    (compare_code_o),
    .a_zero_o (a_is_zero_o),
    .a_neg_o  (a_is_negative_o)
  );

`ifndef NO_ASSERTIONS
  // input back-pressure only when every stage is full and the output is stalled
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (f_valid && m_valid && out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  a_zero_not_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && a_is_zero_o) |-> !a_is_negative_o)
    else $error("operand a flagged both zero and negative");

  a_cmp_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && compare_code_o != CMP_EQ) |->
      (r_limb0_o == '0 && r_limb1_o == '0 && r_limb2_o == '0 && r_limb3_o == '0))
    else $error("compare result carries non-zero limbs");

  a_cmp_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (compare_code_o == CMP_EQ || compare_code_o == CMP_GT ||
                     compare_code_o == CMP_LT))
    else $error("compare code out of range");
`endif

endmodule

`default_nettype wire
